### rtl/core/rbt_pkg.sv
package rbt_pkg;

  localparam int COORD_W    = 32;
  localparam int WEIGHT_W   = 16;
  localparam int BARY_FRAC  = 16;
  localparam int BARY_W     = BARY_FRAC + 1;
  localparam int NUM_SLOTS  = 6;
  localparam int SLOT_W     = 3;
  localparam int BASIS_W    = 2 * BARY_W + 1;
  localparam int BW_W       = BASIS_W + WEIGHT_W;
  localparam int LO_W       = BW_W / 2;
  localparam int HI_W       = BW_W - LO_W;
  localparam int TX_W       = BW_W + COORD_W;
  localparam int NUM_W      = TX_W + 3;
  localparam int DEN_W      = BW_W + 3;
  localparam int MAG_W      = NUM_W;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  typedef struct packed {
    logic                       kind;
    logic [SLOT_W-1:0]          slot;
    logic signed [COORD_W-1:0]  point_x_in;
    logic signed [COORD_W-1:0]  point_y_in;
    logic signed [WEIGHT_W-1:0] weight_in;
    logic [BARY_W-1:0]          bary_one;
    logic [BARY_W-1:0]          bary_two;
    logic [BARY_W-1:0]          bary_three;
  } rbt_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] surface_x;
    logic signed [COORD_W-1:0] surface_y;
    logic                      degenerate;
    logic                      saturated;
  } rbt_out_t;

  typedef struct packed {
    logic               valid;
    logic               neg_x;
    logic               neg_y;
    logic               degen;
    logic [MAG_W-1:0]   num_x;
    logic [MAG_W-1:0]   num_y;
    logic [DEN_W-1:0]   den;
  } rbt_frac_t;

  typedef struct packed {
    logic               valid;
    logic               neg_x;
    logic               neg_y;
    logic               degen;
    logic               ovf_x;
    logic               ovf_y;
    logic [MAG_W-1:0]   rem_x;
    logic [MAG_W-1:0]   rem_y;
    logic [DEN_W-1:0]   den;
    logic [COORD_W-1:0] q_x;
    logic [COORD_W-1:0] q_y;
  } rbt_dstage_t;

endpackage

### rtl/core/rbt_front.sv
module rbt_front
  import rbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  rbt_in_t   in_data,
  output rbt_frac_t frac
);

  logic signed [COORD_W-1:0]  px_r [NUM_SLOTS];
  logic signed [COORD_W-1:0]  py_r [NUM_SLOTS];
  logic signed [WEIGHT_W-1:0] pw_r [NUM_SLOTS];

  logic                       v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [BASIS_W-1:0]         basis_r [NUM_SLOTS];
  logic signed [WEIGHT_W-1:0] w1_r [NUM_SLOTS];
  logic signed [COORD_W-1:0]  x1_r [NUM_SLOTS];
  logic signed [COORD_W-1:0]  y1_r [NUM_SLOTS];
  logic signed [BW_W-1:0]     bw2_r [NUM_SLOTS];
  logic signed [COORD_W-1:0]  x2_r [NUM_SLOTS];
  logic signed [COORD_W-1:0]  y2_r [NUM_SLOTS];
  logic signed [HI_W+COORD_W-1:0] hx3_r [NUM_SLOTS];
  logic signed [HI_W+COORD_W-1:0] hy3_r [NUM_SLOTS];
  logic signed [LO_W+COORD_W:0]   lx3_r [NUM_SLOTS];
  logic signed [LO_W+COORD_W:0]   ly3_r [NUM_SLOTS];
  logic signed [DEN_W-1:0]    den3_r, den4_r, den5_r;
  logic signed [TX_W-1:0]     tx4_r [NUM_SLOTS];
  logic signed [TX_W-1:0]     ty4_r [NUM_SLOTS];
  logic signed [NUM_W-1:0]    nx5_r, ny5_r;
  rbt_frac_t                  frac_r;

  logic [2*BARY_W-1:0]        sq [NUM_SLOTS];
  logic [BASIS_W-1:0]         basis_nxt [NUM_SLOTS];
  logic signed [DEN_W-1:0]    den_nxt;
  logic signed [NUM_W-1:0]    nx_nxt, ny_nxt;
  rbt_frac_t                  frac_nxt;
  logic                       eval_acc;

  assign eval_acc = accept && (in_data.kind == KIND_EVAL);

  always_comb begin
    sq[0] = in_data.bary_one * in_data.bary_one;
    sq[1] = in_data.bary_two * in_data.bary_two;
    sq[2] = in_data.bary_three * in_data.bary_three;
    sq[3] = in_data.bary_one * in_data.bary_two;
    sq[4] = in_data.bary_two * in_data.bary_three;
    sq[5] = in_data.bary_one * in_data.bary_three;
    for (int i = 0; i < 3; i++) begin
      basis_nxt[i] = BASIS_W'(sq[i]);
    end
    for (int i = 3; i < NUM_SLOTS; i++) begin
      basis_nxt[i] = {sq[i], 1'b0};
    end
  end

  always_comb begin
    den_nxt = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      den_nxt = den_nxt + DEN_W'(bw2_r[i]);
    end
    nx_nxt = '0;
    ny_nxt = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      nx_nxt = nx_nxt + NUM_W'(tx4_r[i]);
      ny_nxt = ny_nxt + NUM_W'(ty4_r[i]);
    end
  end

  always_comb begin
    frac_nxt.valid = v5_r;
    frac_nxt.neg_x = nx5_r[NUM_W-1] ^ den5_r[DEN_W-1];
    frac_nxt.neg_y = ny5_r[NUM_W-1] ^ den5_r[DEN_W-1];
    frac_nxt.degen = (den5_r == '0);
    frac_nxt.num_x = nx5_r[NUM_W-1] ? MAG_W'(-nx5_r) : MAG_W'(nx5_r);
    frac_nxt.num_y = ny5_r[NUM_W-1] ? MAG_W'(-ny5_r) : MAG_W'(ny5_r);
    frac_nxt.den   = den5_r[DEN_W-1] ? DEN_W'(-den5_r) : DEN_W'(den5_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        px_r[i] <= '0;
        py_r[i] <= '0;
        pw_r[i] <= '0;
      end
    end else if (accept && (in_data.kind == KIND_LOAD) && (in_data.slot < SLOT_W'(NUM_SLOTS))) begin
      px_r[in_data.slot] <= in_data.point_x_in;
      py_r[in_data.slot] <= in_data.point_y_in;
      pw_r[in_data.slot] <= in_data.weight_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      v5_r         <= 1'b0;
      frac_r.valid <= 1'b0;
    end else begin
      v1_r   <= eval_acc;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      v4_r   <= v3_r;
      v5_r   <= v4_r;
      frac_r <= frac_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      basis_r[i] <= basis_nxt[i];
      w1_r[i]    <= pw_r[i];
      x1_r[i]    <= px_r[i];
      y1_r[i]    <= py_r[i];
      bw2_r[i]   <= BW_W'($signed({1'b0, basis_r[i]}) * w1_r[i]);
      x2_r[i]    <= x1_r[i];
      y2_r[i]    <= y1_r[i];
      hx3_r[i]   <= $signed(bw2_r[i][BW_W-1:LO_W]) * x2_r[i];
      hy3_r[i]   <= $signed(bw2_r[i][BW_W-1:LO_W]) * y2_r[i];
      lx3_r[i]   <= $signed({1'b0, bw2_r[i][LO_W-1:0]}) * x2_r[i];
      ly3_r[i]   <= $signed({1'b0, bw2_r[i][LO_W-1:0]}) * y2_r[i];
      tx4_r[i]   <= (TX_W'(hx3_r[i]) <<< LO_W) + TX_W'(lx3_r[i]);
      ty4_r[i]   <= (TX_W'(hy3_r[i]) <<< LO_W) + TX_W'(ly3_r[i]);
    end
    den3_r <= den_nxt;
    den4_r <= den3_r;
    den5_r <= den4_r;
    nx5_r  <= nx_nxt;
    ny5_r  <= ny_nxt;
  end

  assign frac = frac_r;

endmodule

### rtl/core/rbt_div_step.sv
module rbt_div_step
  import rbt_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  rbt_dstage_t st_in,
  output rbt_dstage_t st_out
);

  rbt_dstage_t      st_r, st_nxt;
  logic [MAG_W-1:0] dsh;

  always_comb begin
    dsh    = MAG_W'(st_in.den) << SHIFT;
    st_nxt = st_in;
    if (st_in.rem_x >= dsh) begin
      st_nxt.rem_x      = st_in.rem_x - dsh;
      st_nxt.q_x[SHIFT] = 1'b1;
    end
    if (st_in.rem_y >= dsh) begin
      st_nxt.rem_y      = st_in.rem_y - dsh;
      st_nxt.q_y[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign st_out = st_r;

endmodule

### rtl/core/rbt_divider.sv
module rbt_divider
  import rbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  rbt_frac_t frac,
  output logic      out_valid,
  output rbt_out_t  out_data
);

  rbt_dstage_t st [COORD_W+1];
  rbt_dstage_t st0_nxt, st0_r;
  rbt_dstage_t last;
  logic [MAG_W:0]     dtop;
  logic               valid_r;
  rbt_out_t           out_r, out_nxt;
  logic [COORD_W-1:0] lim_x, lim_y, mag_x, mag_y;
  logic               sat_x, sat_y;

  always_comb begin
    dtop          = (MAG_W+1)'(frac.den) << COORD_W;
    st0_nxt       = '0;
    st0_nxt.valid = frac.valid;
    st0_nxt.neg_x = frac.neg_x;
    st0_nxt.neg_y = frac.neg_y;
    st0_nxt.degen = frac.degen;
    st0_nxt.ovf_x = {1'b0, frac.num_x} >= dtop;
    st0_nxt.ovf_y = {1'b0, frac.num_y} >= dtop;
    st0_nxt.rem_x = frac.num_x;
    st0_nxt.rem_y = frac.num_y;
    st0_nxt.den   = frac.den;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st0_r.valid <= 1'b0;
    end else begin
      st0_r <= st0_nxt;
    end
  end

  assign st[0] = st0_r;

  for (genvar k = 0; k < COORD_W; k++) begin : g_step
    rbt_div_step #(.SHIFT(COORD_W - 1 - k)) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .st_in  (st[k]),
      .st_out (st[k+1])
    );
  end

  assign last = st[COORD_W];

  always_comb begin
    lim_x = {1'b0, {(COORD_W-1){1'b1}}} + COORD_W'(last.neg_x ^ 1'b0);
    lim_y = {1'b0, {(COORD_W-1){1'b1}}} + COORD_W'(last.neg_y ^ 1'b0);
    sat_x = last.ovf_x || (last.q_x > lim_x);
    sat_y = last.ovf_y || (last.q_y > lim_y);
    mag_x = sat_x ? lim_x : last.q_x;
    mag_y = sat_y ? lim_y : last.q_y;
    if (last.degen) begin
      out_nxt = '0;
      out_nxt.degenerate = 1'b1;
    end else begin
      out_nxt.surface_x  = last.neg_x ? -mag_x : mag_x;
      out_nxt.surface_y  = last.neg_y ? -mag_y : mag_y;
      out_nxt.degenerate = 1'b0;
      out_nxt.saturated  = sat_x || sat_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = out_r;

endmodule

### rtl/core/rational_bezier_triangle_eval_unit.sv
// Channel   Handshake              Payload
// input     start & !busy          in_data   (rbt_in_t)
// result    out_valid, one cycle   out_data  (rbt_out_t)
//
// One item per cycle; busy is always low.
// Evaluate results pass through 6 datapath stages,
// a range check, one stage per quotient bit of the restoring divider, and saturation.
// Loads write the control net at acceptance and give no result.
// Reset clears the control net and all valid bits; the receiver cannot stall.
module rational_bezier_triangle_eval_unit
  import rbt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  rbt_in_t  in_data,
  output logic     out_valid,
  output rbt_out_t out_data
);

  rbt_frac_t frac;
  logic      accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  rbt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .frac    (frac)
  );

  rbt_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .frac      (frac),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### rtl/core/rbt_checker.sv
module rbt_checker
  import rbt_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input rbt_out_t out_data
);

  localparam logic [COORD_W-1:0] MAX_V = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] MIN_V = {1'b1, {(COORD_W-1){1'b0}}};

  a_no_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.surface_x == '0 && out_data.surface_y == '0 && !out_data.saturated)
    else $error("degenerate result not cleared");

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.surface_x == MAX_V || out_data.surface_x == MIN_V ||
      out_data.surface_y == MAX_V || out_data.surface_y == MIN_V)
    else $error("saturated result not at a limit");

  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    !rst_n ##1 !start |=> !out_valid)
    else $error("result without an item");

endmodule

bind rational_bezier_triangle_eval_unit rbt_checker u_rbt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
